### sv/shared_pool_multi_stack_defines.svh
// ----------------------------------------------------------------------------
// shared_pool_multi_stack_defines
// Assertion macros for the shared-pool stack block; NO_ASSERTIONS strips them.
// ----------------------------------------------------------------------------
`ifndef SHARED_POOL_MULTI_STACK_DEFINES_SVH
`define SHARED_POOL_MULTI_STACK_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge, idle while reset is held.
`define SPMS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on every rising edge, also during reset.
`define SPMS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SPMS_ASSERT(label, clk, rstn, prop, msg)
`define SPMS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### sv/spms_pkg.sv
// ----------------------------------------------------------------------------
// spms_pkg
// Item types, operation and status codes, and default sizes of the pool.
// ----------------------------------------------------------------------------
package spms_pkg;

    localparam int DEF_TABLE_SIZE  = 16;
    localparam int DEF_NUM_STACKS  = 3;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int DATA_W      = 32;
    localparam int WIDE_W      = 64;
    localparam int SLOT_IDX_W  = 4;
    localparam int ITEMS_W     = 5;

    localparam logic [1:0] OP_PUSH      = 2'd0;
    localparam logic [1:0] OP_POP       = 2'd1;
    localparam logic [1:0] OP_CLEAR_ONE = 2'd2;
    localparam logic [1:0] OP_CLEAR_ALL = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               operation;
        logic [1:0]               stack_select;
        logic signed [DATA_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] popped_value;
        logic [SLOT_IDX_W-1:0]    slot_index;
        logic [ITEMS_W-1:0]       items_in_use;
    } out_item_t;

endpackage

### sv/spms_mem.sv
// ----------------------------------------------------------------------------
// spms_mem
// Single-port-write, single-port-read slot memory with registered read data.
// ----------------------------------------------------------------------------
module spms_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 38
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/spms_ctrl.sv
// ----------------------------------------------------------------------------
// spms_ctrl
// Sequencer: free-slot scan, pop, chain walk and clearing sweeps on the memory.
// ----------------------------------------------------------------------------
`include "shared_pool_multi_stack_defines.svh"

module spms_ctrl #(
    parameter int TABLE_SIZE  = spms_pkg::DEF_TABLE_SIZE,
    parameter int NUM_STACKS  = spms_pkg::DEF_NUM_STACKS,
    parameter int VALUE_WIDTH = spms_pkg::DEF_VALUE_WIDTH,
    parameter int IDX_W       = $clog2(TABLE_SIZE),
    parameter int ENTRY_W     = VALUE_WIDTH + IDX_W + 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  spms_pkg::in_item_t    s_item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output spms_pkg::out_item_t   res_item,
    output logic                  mem_rd_en,
    output logic [IDX_W-1:0]      mem_rd_addr,
    input  logic [ENTRY_W-1:0]    mem_rd_data,
    output logic                  mem_wr_en,
    output logic [IDX_W-1:0]      mem_wr_addr,
    output logic [ENTRY_W-1:0]    mem_wr_data
);

    import spms_pkg::*;

    localparam int STK_W    = $clog2(NUM_STACKS);
    localparam int CNT_W    = $clog2(TABLE_SIZE + 1);
    localparam int LINK_LO  = VALUE_WIDTH;
    localparam int LV_BIT   = VALUE_WIDTH + IDX_W;
    localparam int USED_BIT = LV_BIT + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SCAN, S_POP, S_WALK, S_SWEEP, S_DONE
    } state_t;

    state_t                  state_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        steps_reg;
    logic [STK_W-1:0]        stk_reg;
    logic [VALUE_WIDTH-1:0]  val_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [IDX_W-1:0]        head_reg [NUM_STACKS];
    logic [NUM_STACKS-1:0]   nonempty_reg;
    logic [1:0]              status_reg;
    logic [DATA_W-1:0]       popped_reg;
    logic [IDX_W-1:0]        slot_reg;

    logic                    accept;
    logic                    sel_ok;
    logic [STK_W-1:0]        sel_idx;
    logic signed [WIDE_W-1:0] push_ext;
    logic                    rd_used;
    logic                    rd_lv;
    logic [IDX_W-1:0]        rd_link;
    logic [WIDE_W-1:0]       rd_val_wide;

    assign s_ready     = (state_reg == S_IDLE);
    assign accept      = s_valid && s_ready;
    assign sel_ok      = (32'(s_item.stack_select) < NUM_STACKS);
    assign sel_idx     = STK_W'(s_item.stack_select);
    assign push_ext    = WIDE_W'(s_item.push_value);
    assign rd_used     = mem_rd_data[USED_BIT];
    assign rd_lv       = mem_rd_data[LV_BIT];
    assign rd_link     = mem_rd_data[LV_BIT-1:LINK_LO];
    assign rd_val_wide = WIDE_W'(mem_rd_data[VALUE_WIDTH-1:0]);

    assign res_valid              = (state_reg == S_DONE);
    assign res_item.status        = status_reg;
    assign res_item.popped_value  = popped_reg;
    assign res_item.slot_index    = SLOT_IDX_W'(slot_reg);
    assign res_item.items_in_use  = ITEMS_W'(count_reg);

    // Memory access decode; every access is at most one read and at most one write
    // per cycle, always to different entries.
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg;
        mem_wr_data = '0;
        unique case (state_reg)
            S_INIT, S_SWEEP: begin
                mem_wr_en = 1'b1;
            end
            S_IDLE: begin
                if (s_valid && sel_ok) begin
                    if (s_item.operation == OP_PUSH) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                    end else if ((s_item.operation == OP_POP ||
                                  s_item.operation == OP_CLEAR_ONE) &&
                                 nonempty_reg[sel_idx]) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = head_reg[sel_idx];
                    end
                end
            end
            S_SCAN: begin
                if (!rd_used) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = {1'b1, nonempty_reg[stk_reg], head_reg[stk_reg], val_reg};
                end else if (idx_reg != LAST_IDX) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg + IDX_W'(1);
                end
            end
            S_POP: begin
                mem_wr_en             = 1'b1;
                mem_wr_data           = mem_rd_data;
                mem_wr_data[USED_BIT] = 1'b0;
            end
            S_WALK: begin
                mem_wr_en             = rd_used;
                mem_wr_data           = mem_rd_data;
                mem_wr_data[USED_BIT] = 1'b0;
                if (rd_lv && steps_reg != LAST_IDX) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = rd_link;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            idx_reg      <= '0;
            count_reg    <= '0;
            nonempty_reg <= '0;
        end else begin
            unique case (state_reg)
                S_INIT: begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg == LAST_IDX) begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        stk_reg    <= sel_idx;
                        val_reg    <= VALUE_WIDTH'(push_ext);
                        status_reg <= STATUS_OK;
                        popped_reg <= '0;
                        slot_reg   <= '0;
                        steps_reg  <= '0;
                        idx_reg    <= '0;
                        if (s_item.operation == OP_CLEAR_ALL) begin
                            nonempty_reg <= '0;
                            count_reg    <= '0;
                            state_reg    <= S_SWEEP;
                        end else if (!sel_ok) begin
                            state_reg <= S_DONE;
                        end else if (s_item.operation == OP_PUSH) begin
                            state_reg <= S_SCAN;
                        end else if (!nonempty_reg[sel_idx]) begin
                            if (s_item.operation == OP_POP) begin
                                status_reg <= STATUS_EMPTY;
                            end
                            state_reg <= S_DONE;
                        end else begin
                            idx_reg   <= head_reg[sel_idx];
                            state_reg <= (s_item.operation == OP_POP) ? S_POP : S_WALK;
                        end
                    end
                end
                S_SCAN: begin
                    if (!rd_used) begin
                        head_reg[stk_reg]     <= idx_reg;
                        nonempty_reg[stk_reg] <= 1'b1;
                        count_reg             <= count_reg + CNT_W'(1);
                        slot_reg              <= idx_reg;
                        state_reg             <= S_DONE;
                    end else if (idx_reg == LAST_IDX) begin
                        status_reg <= STATUS_FULL;
                        state_reg  <= S_DONE;
                    end else begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_POP: begin
                    popped_reg <= rd_val_wide[DATA_W-1:0];
                    slot_reg   <= idx_reg;
                    if (rd_used && count_reg != '0) begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                    head_reg[stk_reg]     <= rd_link;
                    nonempty_reg[stk_reg] <= rd_lv;
                    state_reg             <= S_DONE;
                end
                S_WALK: begin
                    if (rd_used && count_reg != '0) begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                    if (rd_lv && steps_reg != LAST_IDX) begin
                        idx_reg   <= rd_link;
                        steps_reg <= steps_reg + IDX_W'(1);
                    end else begin
                        nonempty_reg[stk_reg] <= 1'b0;
                        state_reg             <= S_DONE;
                    end
                end
                S_SWEEP: begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg == LAST_IDX) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SPMS_ASSERT_ALWAYS(a_no_same_entry, aclk,
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr), "read and write hit one entry")
    `SPMS_ASSERT(a_accept_leaves_idle, aclk, aresetn,
        accept |=> (state_reg != S_IDLE), "accepted item did not start")
    `SPMS_ASSERT(a_push_counts, aclk, aresetn,
        (state_reg == S_SCAN && !rd_used) |=> (count_reg == $past(count_reg) + CNT_W'(1)),
        "push did not count its slot")
    `SPMS_ASSERT(a_count_bound, aclk, aresetn,
        (state_reg == S_DONE) |-> (32'(count_reg) <= TABLE_SIZE), "slot count beyond pool size")

endmodule

### sv/shared_pool_multi_stack.sv
// ----------------------------------------------------------------------------
// shared_pool_multi_stack
// Several linked stacks sharing one pool of slots held in a single memory.
// ----------------------------------------------------------------------------
// NUM_STACKS stacks share TABLE_SIZE slots. A push takes the lowest free slot,
// a pop frees the head slot and returns its value, clear-one frees a stack's
// chain and clear-all frees the whole pool. Each slot entry (used flag, link
// valid, link, value) lives in one memory with a registered read port, and a
// sequencer reads, modifies and writes it back one entry per cycle. One item is
// worked at a time; its result waits in an output register so the next item
// can be accepted while the result is not yet taken. A push reads the slots
// from index 0 up to the first free one, a pop reads and frees the head
// entry, clear-one walks the chain entry by entry and clear-all sweeps every
// entry; a pop or clear-one of an empty stack and any push, pop or clear-one
// with an out-of-range stack select go straight to the result. After reset
// the block sweeps every entry of the memory with s_ready low before it takes
// the first item.
module shared_pool_multi_stack #(
    parameter int TABLE_SIZE  = spms_pkg::DEF_TABLE_SIZE,
    parameter int NUM_STACKS  = spms_pkg::DEF_NUM_STACKS,
    parameter int VALUE_WIDTH = spms_pkg::DEF_VALUE_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  spms_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output spms_pkg::out_item_t m_item
);

    import spms_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int ENTRY_W = VALUE_WIDTH + IDX_W + 2;

    logic               res_valid;
    logic               res_ready;
    out_item_t          res_item;
    logic               m_valid_reg;
    out_item_t          m_item_reg;

    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;

    spms_ctrl #(
        .TABLE_SIZE  (TABLE_SIZE),
        .NUM_STACKS  (NUM_STACKS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W),
        .ENTRY_W     (ENTRY_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_item    (res_item),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    spms_mem #(
        .DEPTH (TABLE_SIZE),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // Output register: take a finished result whenever the slot is empty or
    // being drained this cycle; otherwise hold the sequencer in its done state.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                m_valid_reg <= 1'b1;
                m_item_reg  <= res_item;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### verif/shared_pool_multi_stack_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shared_pool_multi_stack_tb
// Self-checking bench for the three-stack shared slot pool.
// ----------------------------------------------------------------------------
// Drive push, pop and clear items through the input channel and predict each
// result with a cycle-free copy of the pool (used flags, values, links, heads).
// Compare every result field with the oldest prediction. Cover the directed
// corners first (empty pop, extreme values, out-of-range stack, clears), then
// fill the pool to overflow, then run long random traffic biased toward
// filling and emptying the pool, with random gaps on both channels.
// ----------------------------------------------------------------------------
module shared_pool_multi_stack_tb;
    import spms_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int IDLE_LIMIT    = 3000;
    localparam int TAIL_CYCLES   = 40;
    localparam int ITEMS_PER_RUN = 110;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Shadow of the pool, kept in step with every accepted item.
    logic                  pool_used    [DEF_TABLE_SIZE] = '{default: 1'b0};
    logic [DATA_W-1:0]     pool_value   [DEF_TABLE_SIZE] = '{default: '0};
    logic [SLOT_IDX_W-1:0] pool_link    [DEF_TABLE_SIZE] = '{default: '0};
    logic                  pool_link_ok [DEF_TABLE_SIZE] = '{default: 1'b0};
    logic [SLOT_IDX_W-1:0] top_slot     [DEF_NUM_STACKS] = '{default: '0};
    logic                  has_items    [DEF_NUM_STACKS] = '{default: 1'b0};
    int unsigned           occupied     = 0;

    out_item_t   expected_results[$];
    int unsigned error_count  = 0;
    int unsigned result_count = 0;
    int unsigned gap_max      = 18;
    int unsigned stall_max    = 18;
    int unsigned stall_left   = 0;
    int unsigned idle_cycles  = 0;

    shared_pool_multi_stack i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: apply one item to the shadow pool and return its result.
    // ------------------------------------------------------------------------
    function automatic out_item_t pool_apply(in_item_t it);
        out_item_t   r;
        int unsigned s;
        int unsigned idx;
        logic        found;
        logic        more;
        r      = '0;
        s      = 32'(it.stack_select);
        found  = 1'b0;
        idx    = 0;
        if (it.operation == OP_CLEAR_ALL) begin
            // Drop every slot and empty every stack; links and heads stay stale.
            for (int i = 0; i < DEF_TABLE_SIZE; i++) pool_used[i] = 1'b0;
            for (int i = 0; i < DEF_NUM_STACKS; i++) has_items[i] = 1'b0;
            occupied = 0;
        end else if (s < DEF_NUM_STACKS) begin
            case (it.operation)
                OP_PUSH: begin
                    // Take the lowest free slot.
                    for (int i = 0; i < DEF_TABLE_SIZE; i++) begin
                        if (!found && !pool_used[i]) begin
                            found = 1'b1;
                            idx   = i;
                        end
                    end
                    if (!found) begin
                        r.status = STATUS_FULL;
                    end else begin
                        pool_used[idx]    = 1'b1;
                        pool_value[idx]   = it.push_value;
                        pool_link[idx]    = top_slot[s];
                        pool_link_ok[idx] = has_items[s];
                        top_slot[s]       = SLOT_IDX_W'(idx);
                        has_items[s]      = 1'b1;
                        occupied++;
                        r.slot_index      = SLOT_IDX_W'(idx);
                    end
                end
                OP_POP: begin
                    if (!has_items[s]) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        idx            = 32'(top_slot[s]);
                        r.popped_value = pool_value[idx];
                        r.slot_index   = SLOT_IDX_W'(idx);
                        if (pool_used[idx]) begin
                            pool_used[idx] = 1'b0;
                            if (occupied > 0) occupied--;
                        end
                        has_items[s] = pool_link_ok[idx];
                        top_slot[s]  = pool_link[idx];
                    end
                end
                default: begin
                    // Clear one stack: walk its chain, at most one lap of the pool.
                    more = has_items[s];
                    idx  = 32'(top_slot[s]);
                    for (int w = 0; w < DEF_TABLE_SIZE && more; w++) begin
                        if (pool_used[idx]) begin
                            pool_used[idx] = 1'b0;
                            if (occupied > 0) occupied--;
                        end
                        more = pool_link_ok[idx];
                        idx  = 32'(pool_link[idx]);
                    end
                    has_items[s] = 1'b0;
                end
            endcase
        end
        r.items_in_use = ITEMS_W'(occupied);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: idle a random number of cycles, present the item, hold it until
    // accepted, then log the predicted result.
    // ------------------------------------------------------------------------
    task automatic send_item(input in_item_t it);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(pool_apply(it));
    endtask

    task automatic send_op(input logic [1:0] op, input logic [1:0] sel,
                           input logic [DATA_W-1:0] value);
        in_item_t it;
        it.operation    = op;
        it.stack_select = sel;
        it.push_value   = value;
        send_item(it);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // Random item; the two percentages weight push and pop, clears share the rest.
    function automatic in_item_t random_item(int unsigned push_pct, int unsigned pop_pct);
        in_item_t    it;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)                 it.operation = OP_PUSH;
        else if (roll < push_pct + pop_pct)  it.operation = OP_POP;
        else if (roll < 98)                  it.operation = OP_CLEAR_ONE;
        else                                 it.operation = OP_CLEAR_ALL;
        // Mostly valid stacks, now and then the unused select code.
        it.stack_select = ($urandom_range(0, 11) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 15))
            0:       it.push_value = 32'h8000_0000;
            1:       it.push_value = 32'h7fff_ffff;
            2:       it.push_value = 32'h0000_0000;
            3:       it.push_value = 32'hffff_ffff;
            default: it.push_value = $urandom();
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall a random number of cycles after each item, then
    // check the item against the oldest prediction.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("[%0t] result %0d: %s got %0h expected %0h",
                 $realtime, result_count, field, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        out_item_t   want;
        int unsigned stall;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", m_item.popped_value, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_item.status !== want.status)
                    report_mismatch("status", DATA_W'(m_item.status),
                                    DATA_W'(want.status));
                if (m_item.popped_value !== want.popped_value)
                    report_mismatch("popped_value", m_item.popped_value, want.popped_value);
                if (m_item.slot_index !== want.slot_index)
                    report_mismatch("slot_index", DATA_W'(m_item.slot_index),
                                    DATA_W'(want.slot_index));
                if (m_item.items_in_use !== want.items_in_use)
                    report_mismatch("items_in_use", DATA_W'(m_item.items_in_use),
                                    DATA_W'(want.items_in_use));
            end
            result_count++;
            stall = $urandom_range(0, stall_max);
            m_ready    <= (stall == 0);
            stall_left <= stall;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: abort when no item moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Corner items: empty pop, extreme values, out-of-range select, clears.
    task automatic test_directed_corners();
        send_op(OP_POP,       2'd0, 32'h1234_5678);
        send_op(OP_PUSH,      2'd0, 32'h7fff_ffff);
        send_op(OP_PUSH,      2'd1, 32'h8000_0000);
        send_op(OP_PUSH,      2'd2, 32'h0000_0000);
        send_op(OP_PUSH,      2'd0, 32'hffff_ffff);
        send_op(OP_PUSH,      2'd3, 32'h5a5a_a5a5);
        send_op(OP_POP,       2'd3, 32'h0);
        send_op(OP_CLEAR_ONE, 2'd3, 32'h0);
        send_op(OP_POP,       2'd0, 32'h0);
        send_op(OP_POP,       2'd0, 32'h0);
        send_op(OP_POP,       2'd0, 32'h0);
        send_op(OP_CLEAR_ONE, 2'd1, 32'h0);
        send_op(OP_CLEAR_ONE, 2'd1, 32'h0);
        send_op(OP_POP,       2'd2, 32'h0);
        send_op(OP_CLEAR_ALL, 2'd3, 32'hffff_ffff);
        drain_results();
    endtask

    // Fill the pool, overflow it, free a slot and refill, then clear.
    task automatic test_pool_overflow();
        logic [1:0] victim;
        for (int i = 0; i < DEF_TABLE_SIZE; i++)
            send_op(OP_PUSH, 2'($urandom_range(0, 2)), $urandom());
        send_op(OP_PUSH, 2'd1, $urandom());
        victim = has_items[1] ? 2'd1 : (has_items[0] ? 2'd0 : 2'd2);
        send_op(OP_POP,  victim, 32'h0);
        send_op(OP_PUSH, 2'd2, $urandom());
        send_op(OP_PUSH, 2'd0, $urandom());
        send_op(OP_CLEAR_ONE, victim, 32'h0);
        send_op(OP_PUSH, 2'd0, $urandom());
        send_op(OP_CLEAR_ALL, 2'd0, 32'h0);
        drain_results();
    endtask

    // Long random traffic; each run changes idling and fill bias, then pauses
    // until every result is back.
    task automatic test_random_traffic();
        int unsigned push_pct;
        int unsigned pop_pct;
        for (int run = 0; run < 8; run++) begin
            case (run % 4)
                0: begin gap_max = 18; stall_max = 18; end
                1: begin gap_max = 0;  stall_max = 0;  end
                2: begin gap_max = 0;  stall_max = 18; end
                default: begin gap_max = 18; stall_max = 0; end
            endcase
            case (run % 3)
                0: begin push_pct = 70; pop_pct = 25; end
                1: begin push_pct = 30; pop_pct = 62; end
                default: begin push_pct = 48; pop_pct = 42; end
            endcase
            for (int i = 0; i < ITEMS_PER_RUN; i++)
                send_item(random_item(push_pct, pop_pct));
            drain_results();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_pool_overflow();
        test_random_traffic();

        // Let any stray item surface before judging the run.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
